// ----- sv/bresenham_line_rasterizer_macros.svh -----
// Assertion helpers used by the rasterizer RTL.
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

// ante implies cons in the same cycle
`define BLR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cond never holds
`define BLR_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ----- sv/blr_pkg.sv -----
package blr_pkg;

   localparam int COORD_W        = 6;
   localparam int COLOR_W        = 32;
   localparam int DN2_W          = COORD_W + 1;
   localparam int ERR_W          = COORD_W + 1;
   localparam int SUM_W          = COORD_W + 3;
   localparam int CMD_FIFO_DEPTH = 2;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [COLOR_W-1:0] color_type;

   // one classified line, major axis rising
   typedef struct packed {
      logic            steep;
      logic            step_down;
      coord_type       m_start;
      coord_type       n_start;
      coord_type       m_end;
      coord_type       dm;
      logic [DN2_W-1:0] dn2;
      color_type       color;
   } cmd_type;

endpackage

// ----- sv/blr_front.sv -----
module blr_front #(
   parameter int TILE_SIZE = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  blr_pkg::coord_type req_start_x,
   input  blr_pkg::coord_type req_start_y,
   input  blr_pkg::coord_type req_end_x,
   input  blr_pkg::coord_type req_end_y,
   input  blr_pkg::color_type req_line_color,
   output logic               cmd_push,
   output blr_pkg::cmd_type   cmd,
   input  logic               cmd_full
);

   localparam int COORD_LIMIT = 1 << blr_pkg::COORD_W;
   localparam blr_pkg::coord_type COORD_MAX = (TILE_SIZE >= COORD_LIMIT) ?
      blr_pkg::coord_type'(COORD_LIMIT - 1) : blr_pkg::coord_type'(TILE_SIZE - 1);

   logic             front_valid_ff, front_valid_in;
   logic             zero_ff;
   blr_pkg::cmd_type cmd_ff;

   logic             drain, accept;
   blr_pkg::coord_type ax, ay, bx, by, adx, ady;
   blr_pkg::coord_type m0, n0, m1, n1, ms, ns, me, ne;
   logic             steep, swap;
   blr_pkg::cmd_type cmd_in;

   function automatic blr_pkg::coord_type clamp(input blr_pkg::coord_type c);
      return (c > COORD_MAX) ? COORD_MAX : c;
   endfunction

   always_comb begin
      ax = clamp(req_start_x);
      ay = clamp(req_start_y);
      bx = clamp(req_end_x);
      by = clamp(req_end_y);
      adx = (bx > ax) ? bx - ax : ax - bx;
      ady = (by > ay) ? by - ay : ay - by;
      steep = adx < ady;
      m0 = steep ? ay : ax;
      n0 = steep ? ax : ay;
      m1 = steep ? by : bx;
      n1 = steep ? bx : by;
      swap = m0 > m1;
      ms = swap ? m1 : m0;
      ns = swap ? n1 : n0;
      me = swap ? m0 : m1;
      ne = swap ? n0 : n1;
      cmd_in.steep     = steep;
      cmd_in.step_down = !(ne > ns);
      cmd_in.m_start   = ms;
      cmd_in.n_start   = ns;
      cmd_in.m_end     = me;
      cmd_in.dm        = me - ms;
      cmd_in.dn2       = (ne > ns) ? {ne - ns, 1'b0} : {ns - ne, 1'b0};
      cmd_in.color     = req_line_color;
   end

   // zero-span lines are dropped here and never reach the queue
   assign drain          = front_valid_ff && (zero_ff || !cmd_full);
   assign full           = front_valid_ff && !drain;
   assign accept         = push && !full;
   assign cmd_push       = front_valid_ff && !zero_ff && !cmd_full;
   assign cmd            = cmd_ff;
   assign front_valid_in = accept ? 1'b1 : (drain ? 1'b0 : front_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= cmd_in;
         zero_ff <= (cmd_in.dm == '0);
      end
   end

endmodule

// ----- sv/blr_cmd_fifo.sv -----
module blr_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr,
   input  blr_pkg::cmd_type din,
   output logic             full,
   input  logic             rd,
   output blr_pkg::cmd_type dout,
   output logic             empty
);

   localparam int DEPTH = blr_pkg::CMD_FIFO_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   blr_pkg::cmd_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr && !full;
   assign do_rd = rd && !empty;
   assign dout  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- sv/blr_back.sv -----
module blr_back (
   input  logic               clock,
   input  logic               reset,
   input  blr_pkg::cmd_type   cmd,
   input  logic               cmd_empty,
   output logic               cmd_pop,
   output logic               busy,
   output logic               empty,
   input  logic               pop,
   output blr_pkg::coord_type rsp_pixel_x,
   output blr_pkg::coord_type rsp_pixel_y,
   output blr_pkg::color_type rsp_pixel_color,
   output logic               rsp_last_pixel
);

   localparam int ERR_W = blr_pkg::ERR_W;
   localparam int SUM_W = blr_pkg::SUM_W;

   logic active_ff, active_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic                       steep_ff, step_down_ff;
   blr_pkg::coord_type         m_ff, n_ff, m_end_ff, dm_ff;
   logic [blr_pkg::DN2_W-1:0]  dn2_ff;
   blr_pkg::color_type         color_ff;
   logic signed [ERR_W-1:0]    err_ff;

   blr_pkg::coord_type         x_ff, y_ff;
   blr_pkg::color_type         rsp_color_ff;
   logic                       last_ff;

   logic                       out_free, fire, is_last, minor_step;
   logic signed [SUM_W-1:0]    err_sum, err_wrap;

   assign out_free = !rsp_valid_ff || pop;
   assign fire     = active_ff && out_free;
   assign is_last  = (m_ff + 1'b1) == m_end_ff;
   assign cmd_pop  = !cmd_empty && (!active_ff || (fire && is_last));

   // error term: gains 2*|dminor| per step, minor moves once it passes dm
   assign err_sum    = SUM_W'(err_ff) + $signed(SUM_W'(dn2_ff));
   assign minor_step = err_sum > $signed(SUM_W'(dm_ff));
   assign err_wrap   = err_sum - $signed(SUM_W'({dm_ff, 1'b0}));

   assign active_in    = cmd_pop ? 1'b1 : ((fire && is_last) ? 1'b0 : active_ff);
   assign rsp_valid_in = fire ? 1'b1 : (pop ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         steep_ff     <= cmd.steep;
         step_down_ff <= cmd.step_down;
         m_ff         <= cmd.m_start;
         n_ff         <= cmd.n_start;
         m_end_ff     <= cmd.m_end;
         dm_ff        <= cmd.dm;
         dn2_ff       <= cmd.dn2;
         color_ff     <= cmd.color;
         err_ff       <= '0;
      end else if (fire) begin
         m_ff <= m_ff + 1'b1;
         if (minor_step) begin
            n_ff   <= step_down_ff ? n_ff - 1'b1 : n_ff + 1'b1;
            err_ff <= ERR_W'(err_wrap);
         end else begin
            err_ff <= ERR_W'(err_sum);
         end
      end
      if (fire) begin
         x_ff         <= steep_ff ? n_ff : m_ff;
         y_ff         <= steep_ff ? m_ff : n_ff;
         rsp_color_ff <= color_ff;
         last_ff      <= is_last;
      end
   end

   assign busy            = active_ff;
   assign empty           = !rsp_valid_ff;
   assign rsp_pixel_x     = x_ff;
   assign rsp_pixel_y     = y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last_pixel  = last_ff;

endmodule

// ----- sv/bresenham_line_rasterizer.sv -----
// Bresenham line rasterizer for one square tile. A line request (two
// endpoints and a color) is taken on push while full is low; pixels come
// out in order on the rsp_ ports while empty is low and leave on pop, the
// final pixel of each line flagged by rsp_last_pixel. A line whose major span
// is N emits N pixels, one per cycle when pop keeps up; the stepper in the
// back end sets that rate, and it loads the next queued line as it steps
// out the previous line's last pixel. The front end classifies one request
// per cycle while the queue has room, and a two-entry queue decouples it
// from the stepper, so further requests are taken while a line is drawn.
// A request passes the front-end register, queue, stepper and pixel output
// register. Zero-span lines emit nothing and are dropped in the front end.
// Coordinates at or above TILE_SIZE are clamped to TILE_SIZE - 1.
`include "bresenham_line_rasterizer_macros.svh"

module bresenham_line_rasterizer #(
   parameter int TILE_SIZE = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  blr_pkg::coord_type req_start_x,
   input  blr_pkg::coord_type req_start_y,
   input  blr_pkg::coord_type req_end_x,
   input  blr_pkg::coord_type req_end_y,
   input  blr_pkg::color_type req_line_color,
   output logic               empty,
   input  logic               pop,
   output blr_pkg::coord_type rsp_pixel_x,
   output blr_pkg::coord_type rsp_pixel_y,
   output blr_pkg::color_type rsp_pixel_color,
   output logic               rsp_last_pixel
);

   logic             cmd_push, cmd_full, cmd_pop, cmd_empty, back_busy;
   blr_pkg::cmd_type cmd_wr, cmd_rd;

   blr_front #(
      .TILE_SIZE(TILE_SIZE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_line_color(req_line_color),
      .cmd_push      (cmd_push),
      .cmd           (cmd_wr),
      .cmd_full      (cmd_full)
   );

   blr_cmd_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .wr   (cmd_push),
      .din  (cmd_wr),
      .full (cmd_full),
      .rd   (cmd_pop),
      .dout (cmd_rd),
      .empty(cmd_empty)
   );

   blr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd_rd),
      .cmd_empty      (cmd_empty),
      .cmd_pop        (cmd_pop),
      .busy           (back_busy),
      .empty          (empty),
      .pop            (pop),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last_pixel (rsp_last_pixel)
   );

   `BLR_ASSERT_NEVER(a_no_push_when_full, clock, reset, cmd_push && cmd_full, "queue overrun")
   `BLR_ASSERT_NEVER(a_no_pop_when_empty, clock, reset, cmd_pop && cmd_empty, "queue underrun")
   `BLR_ASSERT_IMP(a_line_in_flight, clock, reset, !empty && !rsp_last_pixel, back_busy, "line ended early")

endmodule
